FILE: hw/rtl/ptsd_pkg.sv
// Package for point_to_segment_distance: payload structs and fixed constants.
// No dependencies.
package ptsd_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned TBits  = 16;
    localparam int unsigned DistW  = 33;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_DIV
    } t_cls;

    typedef struct packed {
        logic signed [CoordW-1:0] seg_start_x;
        logic signed [CoordW-1:0] seg_start_y;
        logic signed [CoordW-1:0] seg_end_x;
        logic signed [CoordW-1:0] seg_end_y;
        logic signed [CoordW-1:0] query_x;
        logic signed [CoordW-1:0] query_y;
    } t_in;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [TBits:0]   projection_param;
        logic             degenerate;
    } t_out;

endpackage

FILE: hw/rtl/point_to_segment_distance.sv
// Top level: point to segment distance pipeline.
// Depends on ptsd_pkg, ptsd_div, ptsd_sqrt.
//
//  channel | signals                      | direction
//  input   | i_valid, o_ready, i_data     | in
//  output  | o_valid, i_ready, o_data     | out
//
// One transaction per cycle unless stalled; 8 arithmetic stages, 16 divider
// stages (one per bit of t), 36 root stages (CoordW + 4) and the output register.
// Reset clears valid bits only. A stall at the output freezes the whole pipeline;
// o_ready = i_ready || !o_valid, so no transaction is lost or repeated.
module point_to_segment_distance (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ptsd_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output ptsd_pkg::t_out    o_data
);
    localparam int unsigned CW = ptsd_pkg::CoordW;
    localparam int unsigned DW = CW + 1;
    localparam int unsigned PW = 2 * DW + 2;
    localparam int unsigned TB = ptsd_pkg::TBits;
    localparam int unsigned RW = DW + 2;
    localparam int unsigned SW = 2 * RW + 2;
    localparam int unsigned NDIV = TB;
    localparam int unsigned NSQ = SW / 2;
    localparam int unsigned LAT = 8 + NDIV + NSQ + 1;
    localparam int unsigned DMAX = 33;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en      = i_ready || !o_valid;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // stage 1: differences
    logic signed [DW-1:0] r1_dx, r1_dy, r1_ex, r1_ey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= DW'(i_data.seg_end_x) - DW'(i_data.seg_start_x);
            r1_dy <= DW'(i_data.seg_end_y) - DW'(i_data.seg_start_y);
            r1_ex <= DW'(i_data.query_x) - DW'(i_data.seg_start_x);
            r1_ey <= DW'(i_data.query_y) - DW'(i_data.seg_start_y);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] r2_dxx, r2_dyy, r2_exd, r2_eyd;
    logic signed [DW-1:0] r2_dx, r2_dy, r2_ex, r2_ey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dxx <= PW'(r1_dx) * PW'(r1_dx);
            r2_dyy <= PW'(r1_dy) * PW'(r1_dy);
            r2_exd <= PW'(r1_ex) * PW'(r1_dx);
            r2_eyd <= PW'(r1_ey) * PW'(r1_dy);
            r2_dx <= r1_dx; r2_dy <= r1_dy; r2_ex <= r1_ex; r2_ey <= r1_ey;
        end
    end

    // stage 3: squared length and dot product
    logic signed [PW-1:0] r3_l2, r3_dot;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_ex, r3_ey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_l2  <= r2_dxx + r2_dyy;
            r3_dot <= r2_exd + r2_eyd;
            r3_dx <= r2_dx; r3_dy <= r2_dy; r3_ex <= r2_ex; r3_ey <= r2_ey;
        end
    end

    // stage 4: classify
    ptsd_pkg::t_cls r4_cls;
    logic       r4_deg;
    logic signed [PW-1:0] r4_l2, r4_dot;
    logic signed [DW-1:0] r4_dx, r4_dy, r4_ex, r4_ey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_deg <= r3_l2 == '0;
            if (r3_l2 == '0 || r3_dot[PW-1] || r3_dot == '0) begin
                r4_cls <= ptsd_pkg::CLS_ZERO;
            end else if (r3_dot >= r3_l2) begin
                r4_cls <= ptsd_pkg::CLS_ONE;
            end else begin
                r4_cls <= ptsd_pkg::CLS_DIV;
            end
            r4_l2 <= r3_l2; r4_dot <= r3_dot;
            r4_dx <= r3_dx; r4_dy <= r3_dy; r4_ex <= r3_ex; r4_ey <= r3_ey;
        end
    end

    // divider, with side data delayed alongside
    logic [TB-1:0] div_q;
    logic          div_up;
    ptsd_div #(.W(PW)) u_div (
        .i_clk(i_clk), .i_en(en),
        .i_num(r4_dot), .i_den(r4_l2),
        .o_q(div_q), .o_round_up(div_up)
    );

    ptsd_pkg::t_cls       r_d_cls [NDIV];
    logic                 r_d_deg [NDIV];
    logic signed [DW-1:0] r_d_dx [NDIV], r_d_dy [NDIV], r_d_ex [NDIV], r_d_ey [NDIV];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_cls[0] <= r4_cls; r_d_deg[0] <= r4_deg;
            r_d_dx[0] <= r4_dx; r_d_dy[0] <= r4_dy; r_d_ex[0] <= r4_ex; r_d_ey[0] <= r4_ey;
            for (int k = 1; k < NDIV; k++) begin
                r_d_cls[k] <= r_d_cls[k-1]; r_d_deg[k] <= r_d_deg[k-1];
                r_d_dx[k] <= r_d_dx[k-1]; r_d_dy[k] <= r_d_dy[k-1];
                r_d_ex[k] <= r_d_ex[k-1]; r_d_ey[k] <= r_d_ey[k-1];
            end
        end
    end

    // stage 5: t
    logic [TB:0] r5_t;
    logic        r5_deg;
    logic signed [DW-1:0] r5_dx, r5_dy, r5_ex, r5_ey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_d_cls[NDIV-1])
                ptsd_pkg::CLS_ZERO: r5_t <= '0;
                ptsd_pkg::CLS_ONE:  r5_t <= (TB+1)'(1) << TB;
                default:            r5_t <= {1'b0, div_q} + {{TB{1'b0}}, div_up};
            endcase
            r5_deg <= r_d_deg[NDIV-1];
            r5_dx <= r_d_dx[NDIV-1]; r5_dy <= r_d_dy[NDIV-1];
            r5_ex <= r_d_ex[NDIV-1]; r5_ey <= r_d_ey[NDIV-1];
        end
    end

    // stage 6: t * |d|
    localparam int unsigned OW = DW + TB + 1;
    logic [OW-1:0] r6_ox, r6_oy;
    logic r6_sx, r6_sy, r6_deg;
    logic [TB:0] r6_t;
    logic signed [DW-1:0] r6_ex, r6_ey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ox <= OW'(r5_t) * OW'(r5_dx[DW-1] ? -r5_dx : r5_dx);
            r6_oy <= OW'(r5_t) * OW'(r5_dy[DW-1] ? -r5_dy : r5_dy);
            r6_sx <= r5_dx[DW-1]; r6_sy <= r5_dy[DW-1];
            r6_t <= r5_t; r6_deg <= r5_deg; r6_ex <= r5_ex; r6_ey <= r5_ey;
        end
    end

    // stage 7: residual
    logic [OW-1:0] n7_qx, n7_qy;
    assign n7_qx = (r6_ox + (OW'(1) << (TB-1))) >> TB;
    assign n7_qy = (r6_oy + (OW'(1) << (TB-1))) >> TB;
    logic signed [RW-1:0] r7_rx, r7_ry;
    logic r7_deg;
    logic [TB:0] r7_t;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_rx <= RW'(r6_ex) - (r6_sx ? -RW'(n7_qx) : RW'(n7_qx));
            r7_ry <= RW'(r6_ey) - (r6_sy ? -RW'(n7_qy) : RW'(n7_qy));
            r7_t <= r6_t; r7_deg <= r6_deg;
        end
    end

    // stage 8: squares
    logic [SW-1:0] sq_sum;
    logic [RW-1:0] n8_ax, n8_ay;
    assign n8_ax = r7_rx[RW-1] ? RW'(-r7_rx) : RW'(r7_rx);
    assign n8_ay = r7_ry[RW-1] ? RW'(-r7_ry) : RW'(r7_ry);
    logic [SW-1:0] r8_px, r8_py;
    logic r8_deg;
    logic [TB:0] r8_t;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_px <= SW'(n8_ax) * SW'(n8_ax);
            r8_py <= SW'(n8_ay) * SW'(n8_ay);
            r8_t <= r7_t; r8_deg <= r7_deg;
        end
    end
    assign sq_sum = r8_px + r8_py;

    logic [SW/2:0] root;
    ptsd_sqrt #(.W(SW)) u_sqrt (.i_clk(i_clk), .i_en(en), .i_v(sq_sum), .o_root(root));

    logic [TB:0] r_s_t [NSQ];
    logic        r_s_deg [NSQ];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_t[0] <= r8_t; r_s_deg[0] <= r8_deg;
            for (int k = 1; k < NSQ; k++) begin
                r_s_t[k] <= r_s_t[k-1]; r_s_deg[k] <= r_s_deg[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.distance <= (root > (SW/2+1)'({DMAX{1'b1}})) ? {DMAX{1'b1}}
                               : DMAX'(root);
            o_data.projection_param <= r_s_t[NSQ-1];
            o_data.degenerate       <= r_s_deg[NSQ-1];
        end
    end
endmodule

FILE: hw/rtl/ptsd_div.sv
// Pipelined restoring divider for the projection parameter, one quotient bit per stage.
// Depends on ptsd_pkg.
module ptsd_div #(
    parameter int unsigned W = 68
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [W-1:0]            i_num,
    input  logic [W-1:0]            i_den,
    output logic [ptsd_pkg::TBits-1:0] o_q,
    output logic                    o_round_up
);
    localparam int unsigned N = ptsd_pkg::TBits;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_den [N];
    logic [N-1:0] r_q   [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [W-1:0] s_rem;
        logic [W-1:0] s_den;
        logic [N-1:0] s_q;
        logic [W:0]   n_sh;
        logic         n_ge;
        if (g == 0) begin : g_head
            assign s_rem = i_num;
            assign s_den = i_den;
            assign s_q   = '0;
        end else begin : g_tail
            assign s_rem = r_rem[g-1];
            assign s_den = r_den[g-1];
            assign s_q   = r_q[g-1];
        end
        assign n_sh = {s_rem, 1'b0};
        assign n_ge = n_sh >= {1'b0, s_den};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_ge ? W'(n_sh - {1'b0, s_den}) : W'(n_sh);
                r_den[g] <= s_den;
                r_q[g]   <= {s_q[N-2:0], n_ge};
            end
        end
    end

    assign o_q        = r_q[N-1];
    assign o_round_up = {r_rem[N-1], 1'b0} >= {1'b0, r_den[N-1]};
endmodule

FILE: hw/rtl/ptsd_sqrt.sv
// Pipelined bit-by-bit integer square root with round to nearest.
// No package dependencies.
module ptsd_sqrt #(
    parameter int unsigned W = 136
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_v,
    output logic [W/2:0]   o_root
);
    localparam int unsigned R = W / 2;

    logic [W+1:0] r_rem [R];
    logic [R-1:0] r_s   [R];
    logic [W-1:0] r_v   [R];

    for (genvar g = 0; g < R; g++) begin : g_stage
        logic [W+1:0] s_rem;
        logic [R-1:0] s_s;
        logic [W-1:0] s_v;
        logic [W+1:0] n_rem;
        logic [W+1:0] n_trial;
        if (g == 0) begin : g_head
            assign s_rem = '0;
            assign s_s   = '0;
            assign s_v   = i_v;
        end else begin : g_tail
            assign s_rem = r_rem[g-1];
            assign s_s   = r_s[g-1];
            assign s_v   = r_v[g-1];
        end
        assign n_rem   = {s_rem[W-1:0], s_v[W-1 -: 2]};
        assign n_trial = {{(W-R){1'b0}}, s_s, 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g] <= {s_v[W-3:0], 2'b00};
                if (n_rem >= n_trial) begin
                    r_rem[g] <= n_rem - n_trial;
                    r_s[g]   <= {s_s[R-2:0], 1'b1};
                end else begin
                    r_rem[g] <= n_rem;
                    r_s[g]   <= {s_s[R-2:0], 1'b0};
                end
            end
        end
    end

    // v - s^2 > s  rounds up
    assign o_root = {1'b0, r_s[R-1]}
        + {{R{1'b0}}, (r_rem[R-1] > {{(W+2-R){1'b0}}, r_s[R-1]})};
endmodule

FILE: hw/rtl/ptsd_checker.sv
// Port-level checker for point_to_segment_distance, bound to the top level.
// Depends on ptsd_pkg.
module ptsd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input ptsd_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output not held");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready) else $error("accepted during stall");
    a_tmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.projection_param <= 17'd65536) else $error("t above one");
    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.projection_param == '0)
        else $error("degenerate with nonzero t");
endmodule

bind point_to_segment_distance ptsd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
